FILE: sv/ffsa_pkg.sv
// Package for the first-fit segment allocator: item structs, status codes, FSM states.
// No dependencies.
package ffsa_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = ADDR_W + 1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_PREV_RD,
        S_PREV_CHK,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_WR,
        S_OUT
    } state_t;

endpackage

FILE: sv/ffsa_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/first_fit_segment_allocator.sv
// First-fit segment allocator: free-segment table in one RAM of {start, length}.
// A zero-length item goes straight to the output; otherwise entries are scanned in order,
// shifted as needed for a removal or an insert, and written before the result is output.
// One item at a time; the next item is taken in S_IDLE, after the result is loaded
// into the output register.
// Reset (async, active low) and heap_size writes leave a single free segment
// [0, heap_size), or an empty table for a zero heap; entry 0 is written directly.
// Depends on ffsa_pkg and ffsa_ram.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ffsa_pkg::req_t            in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ffsa_pkg::rsp_t            out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ffsa_pkg::LEN_W-1:0] cfg_data
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int LW = ffsa_pkg::LEN_W;
    localparam int EW = AW + LW;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam logic [LW:0] LMAX = {1'b0, {LW{1'b1}}};

    ffsa_pkg::state_t state_reg, state_next;
    ffsa_pkg::req_t   req_reg;
    ffsa_pkg::rsp_t   rsp_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    idx_reg;     // scan / shift pointer
    logic [CW-1:0]    pos_reg;     // hit position
    logic [EW-1:0]    hit_reg;     // entry at pos
    logic [EW-1:0]    prv_reg;     // entry at pos-1
    logic             mrg_prev_reg; // merge with entry pos-1
    logic             mrg_next_reg; // merge with entry pos
    logic             init_reg;    // entry 0 needs init write
    logic [LW-1:0]    heap_reg;

    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [EW-1:0]    wdata, rdata;

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // predecessor comes straight from the RAM while it is being checked
    logic [EW-1:0] p_ent;
    assign p_ent = (state_reg == ffsa_pkg::S_PREV_CHK) ? rdata : prv_reg;

    logic [AW-1:0] r_st, p_st, h_st;
    logic [LW-1:0] r_ln, p_ln, h_ln;
    assign r_st = rdata[EW-1:LW];
    assign r_ln = rdata[LW-1:0];
    assign p_st = p_ent[EW-1:LW];
    assign p_ln = p_ent[LW-1:0];
    assign h_st = hit_reg[EW-1:LW];
    assign h_ln = hit_reg[LW-1:0];

    logic alloc_op, is_free;
    assign is_free  = (req_reg.operation == ffsa_pkg::OP_FREE);
    assign alloc_op = !is_free;

    // hit test on freshly read entry
    logic hit_now;
    assign hit_now = alloc_op ? (r_ln >= req_reg.length) : (r_st >= req_reg.address);

    // adjacency for free; ends are kept wide enough not to wrap
    logic prev_adj, next_adj, have_prev, have_next;
    logic [AW+1:0] p_end, n_end;
    assign have_prev = (pos_reg != '0);
    assign have_next = (pos_reg < cnt_reg);
    assign p_end = {2'b00, p_st} + {1'b0, p_ln};
    assign n_end = {2'b00, req_reg.address} + {1'b0, req_reg.length};
    assign prev_adj = have_prev && (p_end == {2'b00, req_reg.address});
    assign next_adj = have_next && (n_end == {2'b00, h_st});

    // saturated merges
    logic [LW+1:0] sum_pn, sum_p, sum_n;
    logic [LW-1:0] sat_pn, sat_p, sat_n;
    assign sum_pn = {2'b0, p_ln} + {2'b0, req_reg.length} + {2'b0, h_ln};
    assign sum_p  = {2'b0, p_ln} + {2'b0, req_reg.length};
    assign sum_n  = {2'b0, h_ln} + {2'b0, req_reg.length};
    assign sat_pn = (sum_pn > {1'b0, LMAX}) ? LMAX[LW-1:0] : sum_pn[LW-1:0];
    assign sat_p  = (sum_p  > {1'b0, LMAX}) ? LMAX[LW-1:0] : sum_p[LW-1:0];
    assign sat_n  = (sum_n  > {1'b0, LMAX}) ? LMAX[LW-1:0] : sum_n[LW-1:0];

    logic scan_end;
    assign scan_end = (idx_reg >= cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (in_valid && !init_reg && !cfg_valid)
                begin
                    if (in_data.length == '0)
                    begin
                        state_next = ffsa_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::S_RD;
                    end
                end
            end
            ffsa_pkg::S_RD:
            begin
                if (scan_end)
                begin
                    state_next = is_free ? ffsa_pkg::S_PREV_RD : ffsa_pkg::S_OUT;
                end
                else
                begin
                    state_next = ffsa_pkg::S_CHK;
                end
            end
            ffsa_pkg::S_CHK:
            begin
                if (hit_now)
                begin
                    if (alloc_op)
                    begin
                        state_next = (r_ln == req_reg.length) ?
                                     ffsa_pkg::S_SHL_RD : ffsa_pkg::S_WR;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::S_PREV_RD;
                    end
                end
                else
                begin
                    state_next = ffsa_pkg::S_RD;
                end
            end
            ffsa_pkg::S_PREV_RD:  state_next = ffsa_pkg::S_PREV_CHK;
            ffsa_pkg::S_PREV_CHK:
            begin
                if (prev_adj && next_adj)
                begin
                    state_next = ffsa_pkg::S_SHL_RD;
                end
                else if (prev_adj || next_adj)
                begin
                    state_next = ffsa_pkg::S_WR;
                end
                else if (cnt_reg >= MAXC)
                begin
                    state_next = ffsa_pkg::S_OUT;
                end
                else
                begin
                    state_next = ffsa_pkg::S_SHR_RD;
                end
            end
            ffsa_pkg::S_SHL_RD:
            begin
                state_next = (idx_reg + 1'b1 >= cnt_reg) ? ffsa_pkg::S_WR : ffsa_pkg::S_SHL_WR;
            end
            ffsa_pkg::S_SHL_WR:  state_next = ffsa_pkg::S_SHL_RD;
            ffsa_pkg::S_SHR_RD:
            begin
                state_next = (idx_reg <= pos_reg) ? ffsa_pkg::S_WR : ffsa_pkg::S_SHR_WR;
            end
            ffsa_pkg::S_SHR_WR:  state_next = ffsa_pkg::S_SHR_RD;
            ffsa_pkg::S_WR:      state_next = ffsa_pkg::S_OUT;
            ffsa_pkg::S_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default:             state_next = ffsa_pkg::S_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[IW-1:0];
        unique case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                we    = init_reg;
                wdata = {{AW{1'b0}}, heap_reg};
            end
            ffsa_pkg::S_PREV_RD:
            begin
                raddr = IW'(pos_reg - 1'b1);
            end
            ffsa_pkg::S_SHL_RD:
            begin
                raddr = IW'(idx_reg + 1'b1);
            end
            ffsa_pkg::S_SHL_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                wdata = rdata;
            end
            ffsa_pkg::S_SHR_RD:
            begin
                raddr = IW'(idx_reg - 1'b1);
            end
            ffsa_pkg::S_SHR_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                wdata = rdata;
            end
            ffsa_pkg::S_WR:
            begin
                if (alloc_op)
                begin
                    // exact fit already shifted out; only shortening writes
                    we    = (h_ln != req_reg.length);
                    waddr = pos_reg[IW-1:0];
                    wdata = {AW'(h_st + req_reg.length[AW-1:0]), LW'(h_ln - req_reg.length)};
                end
                else if (mrg_prev_reg && mrg_next_reg)
                begin
                    we    = 1'b1;
                    waddr = IW'(pos_reg - 1'b1);
                    wdata = {p_st, sat_pn};
                end
                else if (mrg_prev_reg)
                begin
                    we    = 1'b1;
                    waddr = IW'(pos_reg - 1'b1);
                    wdata = {p_st, sat_p};
                end
                else if (mrg_next_reg)
                begin
                    we    = 1'b1;
                    waddr = pos_reg[IW-1:0];
                    wdata = {req_reg.address, sat_n};
                end
                else
                begin
                    we    = 1'b1;
                    waddr = pos_reg[IW-1:0];
                    wdata = {req_reg.address, req_reg.length};
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ffsa_pkg::S_IDLE) || init_reg || cfg_valid;
    assign cfg_ready = (state_reg == ffsa_pkg::S_IDLE);

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffsa_pkg::S_IDLE;
            cnt_reg      <= CW'(1);
            heap_reg     <= LW'(1) << AW;
            init_reg     <= 1'b1;
            out_valid    <= 1'b0;
            out_data     <= '0;
            req_reg      <= '0;
            rsp_reg      <= '0;
            hit_reg      <= '0;
            prv_reg      <= '0;
            mrg_prev_reg <= 1'b0;
            mrg_next_reg <= 1'b0;
            idx_reg      <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && !out_stall && state_reg != ffsa_pkg::S_OUT)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ffsa_pkg::S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        heap_reg <= cfg_data;
                        cnt_reg  <= (cfg_data == '0) ? '0 : CW'(1);
                        init_reg <= 1'b1;
                    end
                    else if (init_reg)
                    begin
                        init_reg <= 1'b0;
                    end
                    else if (in_valid)
                    begin
                        req_reg <= in_data;
                        idx_reg <= '0;
                        pos_reg <= cnt_reg;
                        rsp_reg <= {{AW{1'b0}}, (in_data.operation == ffsa_pkg::OP_FREE) ?
                                    ffsa_pkg::ST_OK : ffsa_pkg::ST_NO_FIT};
                    end
                end
                ffsa_pkg::S_RD:
                begin
                    if (scan_end)
                    begin
                        pos_reg <= cnt_reg;
                    end
                end
                ffsa_pkg::S_CHK:
                begin
                    hit_reg <= rdata;
                    if (hit_now)
                    begin
                        pos_reg <= idx_reg;
                        if (alloc_op)
                        begin
                            rsp_reg <= {r_st, ffsa_pkg::ST_OK};
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ffsa_pkg::S_PREV_CHK:
                begin
                    prv_reg      <= rdata;
                    mrg_prev_reg <= prev_adj;
                    mrg_next_reg <= next_adj;
                end
                ffsa_pkg::S_SHL_RD:
                begin
                    // remove entry at idx: start at pos (alloc) or pos (merge both)
                    if (idx_reg + 1'b1 >= cnt_reg)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ffsa_pkg::S_SHL_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ffsa_pkg::S_SHR_RD:
                begin
                    if (idx_reg <= pos_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ffsa_pkg::S_SHR_WR:
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
                ffsa_pkg::S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        out_data  <= rsp_reg;
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
            // shift setup after the hit/prev decision
            if (state_reg == ffsa_pkg::S_CHK && hit_now && alloc_op && r_ln == req_reg.length)
            begin
                idx_reg <= idx_reg;
            end
            if (state_reg == ffsa_pkg::S_PREV_CHK)
            begin
                if (prev_adj && next_adj)
                begin
                    idx_reg <= pos_reg;
                end
                else if (!prev_adj && !next_adj)
                begin
                    if (cnt_reg >= MAXC)
                    begin
                        rsp_reg <= {{AW{1'b0}}, ffsa_pkg::ST_FULL};
                    end
                    idx_reg <= cnt_reg;
                end
            end
        end
    end

endmodule
